// ----- sv/hps_pkg.sv -----
package hps_pkg;

   localparam int PWM_BITS_DEF = 10;

   localparam int CODE_W     = 4;
   localparam int TIME_W     = 32;
   localparam int SPEED_W    = 18;
   localparam int FRAC_W     = 17;
   localparam int ACCEL_W    = 24;
   localparam int DUTY_OUT_W = 10;
   localparam int PHASE_W    = 2;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 24;
   localparam int STEP_W     = 18;

   localparam logic [FRAC_W-1:0]  FULL_Q16  = FRAC_W'(65536);
   localparam logic [SPEED_W-1:0] DEAD_BAND = SPEED_W'(655);
   localparam logic [STEP_W-1:0]  STEP_MAX  = {STEP_W{1'b1}};

   // A dt that needs more than DT_KEEP_W bits always saturates the step
   // (any nonzero rate times 2^28 ms exceeds 1000 * STEP_MAX).
   localparam int DT_KEEP_W = 28;
   localparam int PROD_W    = ACCEL_W + DT_KEEP_W;
   localparam int DIV8_SH   = 3;
   localparam int QUOT_IN_W = DT_KEEP_W - DIV8_SH;

   // floor(x / 125) = (x * RECIP_125) >> RECIP_SHIFT for x < 2^QUOT_IN_W
   localparam int RECIP_W       = 26;
   localparam int RECIP_SHIFT   = 32;
   localparam logic [RECIP_W-1:0] RECIP_125 = RECIP_W'(34359739);
   localparam int RECIP_PROD_W  = QUOT_IN_W + RECIP_W;
   localparam int QUOT_W        = RECIP_PROD_W - RECIP_SHIFT;

   typedef enum logic [CODE_W-1:0] {
      REQ_TICK       = 4'd0,
      REQ_SET_SPEED  = 4'd1,
      REQ_TIMED_MOVE = 4'd2,
      REQ_FORWARD    = 4'd3,
      REQ_BACK       = 4'd4,
      REQ_STOP       = 4'd5,
      REQ_BRAKE      = 4'd6,
      REQ_COAST      = 4'd7,
      REQ_ENABLE     = 4'd8,
      REQ_DISABLE    = 4'd9,
      REQ_SLEEP      = 4'd10,
      REQ_WAKE       = 4'd11
   } hps_code_type;

   typedef enum logic [PHASE_W-1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_CONST = 2'd1,
      PHASE_ACCEL = 2'd2,
      PHASE_DECEL = 2'd3
   } hps_phase_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MAX_SPEED  = 2'd0,
      CSR_ACCEL      = 2'd1,
      CSR_SLEEP_INV  = 2'd2,
      CSR_ENABLE_INV = 2'd3
   } hps_csr_type;

   typedef struct packed {
      logic [FRAC_W-1:0]  max_speed;
      logic [ACCEL_W-1:0] accel_rate;
      logic               sleep_inv;
      logic               enable_inv;
   } hps_cfg_type;

   typedef struct packed {
      logic [CODE_W-1:0]    code;
      logic [TIME_W-1:0]    now_ms;
      logic [TIME_W-1:0]    move_ms;
      logic [SPEED_W-1:0]   tgt_set;
      logic [FRAC_W-1:0]    lim;
      logic                 dt_zero;
      logic                 sat;
      logic [QUOT_IN_W-1:0] quot_in;
   } hps_mid_type;

   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic [TIME_W-1:0]  now_ms;
      logic [TIME_W-1:0]  move_ms;
      logic [SPEED_W-1:0] tgt_set;
      logic [FRAC_W-1:0]  lim;
      logic               dt_zero;
      logic [STEP_W-1:0]  step;
   } hps_item_type;

endpackage

// ----- sv/hps_if.sv -----
interface hps_req_if;
   import hps_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CODE_W-1:0]         req_type;
   logic [TIME_W-1:0]         now_ms;
   logic signed [SPEED_W-1:0] speed_value;
   logic signed [TIME_W-1:0]  move_ms;
   modport source (output valid, req_type, now_ms, speed_value, move_ms, input ready);
   modport sink   (input valid, req_type, now_ms, speed_value, move_ms, output ready);
endinterface

interface hps_rsp_if;
   import hps_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [DUTY_OUT_W-1:0]     duty_in1;
   logic [DUTY_OUT_W-1:0]     duty_in2;
   logic                      sleep_pin;
   logic                      enable_pin;
   logic signed [SPEED_W-1:0] speed_now;
   logic signed [SPEED_W-1:0] speed_goal;
   logic                      in_motion;
   logic [PHASE_W-1:0]        ramp_phase;
   modport source (output valid, duty_in1, duty_in2, sleep_pin, enable_pin, speed_now,
                   speed_goal, in_motion, ramp_phase, input ready);
   modport sink   (input valid, duty_in1, duty_in2, sleep_pin, enable_pin, speed_now,
                   speed_goal, in_motion, ramp_phase, output ready);
endinterface

interface hps_csr_if;
   import hps_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

// ----- sv/hps_front.sv -----
module hps_front (
   input  logic                 clock,
   input  logic                 reset,
   input  hps_pkg::hps_cfg_type cfg,
   hps_req_if.sink              req_bus,
   output logic                 item_valid,
   output hps_pkg::hps_item_type item,
   input  logic                 item_ready
);
   import hps_pkg::*;

   logic                 s1_v_ff, s1_v_in;
   logic [CODE_W-1:0]    code_ff;
   logic [TIME_W-1:0]    now_ff;
   logic [SPEED_W-1:0]   speed_ff;
   logic [TIME_W-1:0]    move_ff;
   logic [TIME_W-1:0]    last_tick_ff, last_tick_in;
   logic                 mid_v_ff, mid_v_in;
   hps_mid_type          mid_ff, mid_in;
   logic                 item_v_ff, item_v_in;
   hps_item_type         item_ff, item_in;

   logic                 item_rdy, mid_rdy, s1_rdy, s1_adv, mid_adv;
   logic [FRAC_W-1:0]    lim;
   logic                 spd_neg;
   logic [SPEED_W-1:0]   spd_abs;
   logic [FRAC_W-1:0]    spd_mag;
   logic [2*FRAC_W-1:0]  scaled;
   logic [FRAC_W-1:0]    tgt_mag;
   logic [TIME_W-1:0]    dt;
   logic [PROD_W-1:0]    prod;
   logic [RECIP_PROD_W-1:0] recip_prod;
   logic [QUOT_W-1:0]    quot;
   logic                 stamps_tick;

   // pipeline handshake: a stage takes a beat when it is empty or drains
   assign item_rdy      = !item_v_ff || item_ready;
   assign mid_rdy       = !mid_v_ff || item_rdy;
   assign s1_rdy        = !s1_v_ff || mid_rdy;
   assign s1_adv        = s1_v_ff && mid_rdy;
   assign mid_adv       = mid_v_ff && item_rdy;
   assign req_bus.ready = s1_rdy && !reset;
   assign item_valid    = item_v_ff;
   assign item          = item_ff;

   always_comb begin
      s1_v_in = s1_v_ff;
      if (s1_rdy) begin
         s1_v_in = req_bus.valid;
      end
      mid_v_in = mid_v_ff;
      if (mid_rdy) begin
         mid_v_in = s1_v_ff;
      end
      item_v_in = item_v_ff;
      if (item_rdy) begin
         item_v_in = mid_v_ff;
      end
   end

   // stage one: limit, set-speed scaling, elapsed time times rate
   always_comb begin
      lim     = (cfg.max_speed > FULL_Q16) ? FULL_Q16 : cfg.max_speed;
      spd_neg = speed_ff[SPEED_W-1];
      spd_abs = spd_neg ? (SPEED_W'(0) - speed_ff) : speed_ff;
      spd_mag = (spd_abs > {1'b0, FULL_Q16}) ? FULL_Q16 : spd_abs[FRAC_W-1:0];
      scaled  = (2*FRAC_W)'(spd_mag) * (2*FRAC_W)'(lim);
      tgt_mag = scaled[FRAC_W+15:16];
      dt      = now_ff - last_tick_ff;
      prod    = PROD_W'(cfg.accel_rate) * PROD_W'(dt[DT_KEEP_W-1:0]);

      mid_in.code    = code_ff;
      mid_in.now_ms  = now_ff;
      mid_in.move_ms = move_ff;
      mid_in.tgt_set = spd_neg ? (SPEED_W'(0) - SPEED_W'(tgt_mag)) : SPEED_W'(tgt_mag);
      mid_in.lim     = lim;
      mid_in.dt_zero = (dt == '0);
      mid_in.sat     = (|dt[TIME_W-1:DT_KEEP_W]) || (|prod[PROD_W-1:DT_KEEP_W]);
      mid_in.quot_in = prod[DT_KEEP_W-1:DIV8_SH];
   end

   // last tick stamp depends only on the beat itself, so track it here
   always_comb begin
      stamps_tick = (code_ff == REQ_TICK) || (code_ff == REQ_FORWARD) ||
                    (code_ff == REQ_BACK) ||
                    ((code_ff == REQ_TIMED_MOVE) && (move_ff != '0));
      last_tick_in = last_tick_ff;
      if (s1_adv && stamps_tick) begin
         last_tick_in = now_ff;
      end
   end

   // stage two: divide by 1000 as (x / 8) / 125 by reciprocal
   always_comb begin
      recip_prod      = RECIP_PROD_W'(mid_ff.quot_in) * RECIP_PROD_W'(RECIP_125);
      quot            = recip_prod[RECIP_PROD_W-1:RECIP_SHIFT];
      item_in.code    = mid_ff.code;
      item_in.now_ms  = mid_ff.now_ms;
      item_in.move_ms = mid_ff.move_ms;
      item_in.tgt_set = mid_ff.tgt_set;
      item_in.lim     = mid_ff.lim;
      item_in.dt_zero = mid_ff.dt_zero;
      item_in.step    = (mid_ff.sat || (quot > QUOT_W'(STEP_MAX))) ? STEP_MAX
                                                                  : quot[STEP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         mid_v_ff     <= 1'b0;
         item_v_ff    <= 1'b0;
         last_tick_ff <= '0;
      end else begin
         s1_v_ff      <= s1_v_in;
         mid_v_ff     <= mid_v_in;
         item_v_ff    <= item_v_in;
         last_tick_ff <= last_tick_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         code_ff  <= req_bus.req_type;
         now_ff   <= req_bus.now_ms;
         speed_ff <= req_bus.speed_value;
         move_ff  <= req_bus.move_ms;
      end
      if (s1_adv) begin
         mid_ff <= mid_in;
      end
      if (mid_adv) begin
         item_ff <= item_in;
      end
   end

endmodule

// ----- sv/hps_core.sv -----
module hps_core #(
   parameter int PWM_BITS = hps_pkg::PWM_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hps_pkg::hps_cfg_type  cfg,
   input  logic                  item_valid,
   input  hps_pkg::hps_item_type item,
   output logic                  item_ready,
   hps_rsp_if.source             rsp_bus
);
   import hps_pkg::*;

   localparam int SCALE_W = FRAC_W + PWM_BITS;
   localparam logic [PWM_BITS-1:0] DUTY_FULL = {PWM_BITS{1'b1}};

   logic                      out_v_ff, out_v_in;
   logic signed [SPEED_W-1:0] cur_ff, cur_in;
   logic signed [SPEED_W-1:0] tgt_ff, tgt_in;
   logic                      act_ff, act_in;
   logic [TIME_W-1:0]         len_ff, len_in;
   logic [TIME_W-1:0]         begin_ff, begin_in;
   logic                      en_ff, en_in;
   logic                      awake_ff, awake_in;
   logic [PWM_BITS-1:0]       duty_a_ff, duty_a_in;
   logic [PWM_BITS-1:0]       duty_b_ff, duty_b_in;

   logic                      fire, accel_zero, move_done, do_drive, use_imm, reach;
   logic [TIME_W-1:0]         elapsed;
   logic signed [SPEED_W:0]   diff;
   logic [SPEED_W:0]          diff_abs;
   logic signed [SPEED_W:0]   stepped;
   logic signed [SPEED_W-1:0] ramp_cur, lim_pos, lim_neg;
   logic [SPEED_W-1:0]        drv_abs;
   logic [SCALE_W-1:0]        drv_scaled;
   logic [PWM_BITS-1:0]       drv_mag;
   logic [SPEED_W-1:0]        cur_abs, tgt_abs;
   hps_phase_type             phase;
   logic [PWM_BITS+DUTY_OUT_W-1:0] duty_a_ext, duty_b_ext;

   assign item_ready = !out_v_ff || rsp_bus.ready;
   assign fire       = item_valid && item_ready;
   assign accel_zero = (cfg.accel_rate == '0);

   always_comb begin
      out_v_in = out_v_ff;
      if (fire) begin
         out_v_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_v_in = 1'b0;
      end
   end

   // ramp toward the target by the precomputed step
   always_comb begin
      elapsed   = item.now_ms - begin_ff;
      move_done = act_ff && (len_ff != '0) && (elapsed >= len_ff);
      diff      = (SPEED_W+1)'(tgt_ff) - (SPEED_W+1)'(cur_ff);
      diff_abs  = diff[SPEED_W] ? ((SPEED_W+1)'(0) - diff) : diff;
      reach     = (diff_abs[SPEED_W-1:0] <= item.step);
      stepped   = diff[SPEED_W] ? ((SPEED_W+1)'(cur_ff) - (SPEED_W+1)'(item.step))
                                : ((SPEED_W+1)'(cur_ff) + (SPEED_W+1)'(item.step));
      ramp_cur  = (accel_zero || reach) ? tgt_ff : stepped[SPEED_W-1:0];
      lim_pos   = $signed(SPEED_W'(item.lim));
      lim_neg   = $signed(SPEED_W'(0) - SPEED_W'(item.lim));
   end

   always_comb begin
      cur_in    = cur_ff;
      tgt_in    = tgt_ff;
      act_in    = act_ff;
      len_in    = len_ff;
      begin_in  = begin_ff;
      en_in     = en_ff;
      awake_in  = awake_ff;
      duty_a_in = duty_a_ff;
      duty_b_in = duty_b_ff;
      do_drive  = 1'b0;
      use_imm   = 1'b0;

      case (item.code)
         REQ_TICK: begin
            if (move_done) begin
               tgt_in   = '0;
               cur_in   = '0;
               act_in   = 1'b0;
               len_in   = '0;
               do_drive = 1'b1;
            end else if ((cur_ff != tgt_ff) && !item.dt_zero) begin
               cur_in   = ramp_cur;
               do_drive = 1'b1;
            end
         end
         REQ_SET_SPEED: begin
            tgt_in  = $signed(item.tgt_set);
            act_in  = (item.tgt_set != '0);
            use_imm = 1'b1;
         end
         REQ_TIMED_MOVE: begin
            if (item.move_ms != '0) begin
               len_in   = item.move_ms[TIME_W-1] ? (TIME_W'(0) - item.move_ms)
                                                 : item.move_ms;
               begin_in = item.now_ms;
               act_in   = 1'b1;
               tgt_in   = item.move_ms[TIME_W-1] ? lim_neg : lim_pos;
               use_imm  = 1'b1;
            end
         end
         REQ_FORWARD, REQ_BACK: begin
            tgt_in  = (item.code == REQ_FORWARD) ? lim_pos : lim_neg;
            act_in  = 1'b1;
            len_in  = '0;
            use_imm = 1'b1;
         end
         REQ_STOP: begin
            tgt_in  = '0;
            act_in  = 1'b0;
            use_imm = 1'b1;
         end
         REQ_BRAKE: begin
            duty_a_in = DUTY_FULL;
            duty_b_in = DUTY_FULL;
            cur_in    = '0;
            tgt_in    = '0;
            act_in    = 1'b0;
         end
         REQ_COAST: begin
            duty_a_in = '0;
            duty_b_in = '0;
            cur_in    = '0;
            tgt_in    = '0;
            act_in    = 1'b0;
         end
         REQ_ENABLE: begin
            en_in    = 1'b1;
            awake_in = 1'b1;
         end
         REQ_DISABLE: begin
            duty_a_in = '0;
            duty_b_in = '0;
            cur_in    = '0;
            tgt_in    = '0;
            act_in    = 1'b0;
            en_in     = 1'b0;
         end
         REQ_SLEEP: begin
            awake_in = 1'b0;
            cur_in   = '0;
            tgt_in   = '0;
            act_in   = 1'b0;
         end
         REQ_WAKE: begin
            awake_in = 1'b1;
         end
         default: begin
         end
      endcase

      // zero rate: jump straight to the new target
      if (use_imm && accel_zero) begin
         cur_in   = tgt_in;
         do_drive = 1'b1;
      end

      drv_abs    = cur_in[SPEED_W-1] ? (SPEED_W'(0) - SPEED_W'(cur_in)) : SPEED_W'(cur_in);
      drv_scaled = (SCALE_W'(drv_abs[FRAC_W-1:0]) << PWM_BITS) -
                   SCALE_W'(drv_abs[FRAC_W-1:0]);
      drv_mag    = drv_scaled[PWM_BITS+15:16];

      if (do_drive) begin
         if (cur_in > $signed(DEAD_BAND)) begin
            duty_a_in = drv_mag;
            duty_b_in = '0;
         end else if (cur_in < -$signed(DEAD_BAND)) begin
            duty_a_in = '0;
            duty_b_in = drv_mag;
         end else begin
            duty_a_in = '0;
            duty_b_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         cur_ff    <= '0;
         tgt_ff    <= '0;
         act_ff    <= 1'b0;
         len_ff    <= '0;
         begin_ff  <= '0;
         en_ff     <= 1'b1;
         awake_ff  <= 1'b1;
         duty_a_ff <= '0;
         duty_b_ff <= '0;
      end else begin
         out_v_ff <= out_v_in;
         if (fire) begin
            cur_ff    <= cur_in;
            tgt_ff    <= tgt_in;
            act_ff    <= act_in;
            len_ff    <= len_in;
            begin_ff  <= begin_in;
            en_ff     <= en_in;
            awake_ff  <= awake_in;
            duty_a_ff <= duty_a_in;
            duty_b_ff <= duty_b_in;
         end
      end
   end

   // ramp phase from the settled state
   always_comb begin
      cur_abs = cur_ff[SPEED_W-1] ? (SPEED_W'(0) - SPEED_W'(cur_ff)) : SPEED_W'(cur_ff);
      tgt_abs = tgt_ff[SPEED_W-1] ? (SPEED_W'(0) - SPEED_W'(tgt_ff)) : SPEED_W'(tgt_ff);
      if (!en_ff || (!act_ff && (cur_ff == '0))) begin
         phase = PHASE_IDLE;
      end else if (cur_ff == tgt_ff) begin
         phase = PHASE_CONST;
      end else if (cur_abs < tgt_abs) begin
         phase = PHASE_ACCEL;
      end else begin
         phase = PHASE_DECEL;
      end
   end

   assign duty_a_ext = (PWM_BITS+DUTY_OUT_W)'(duty_a_ff);
   assign duty_b_ext = (PWM_BITS+DUTY_OUT_W)'(duty_b_ff);

   assign rsp_bus.valid      = out_v_ff;
   assign rsp_bus.duty_in1   = duty_a_ext[DUTY_OUT_W-1:0];
   assign rsp_bus.duty_in2   = duty_b_ext[DUTY_OUT_W-1:0];
   assign rsp_bus.sleep_pin  = awake_ff ^ cfg.sleep_inv;
   assign rsp_bus.enable_pin = (en_ff == cfg.enable_inv);
   assign rsp_bus.speed_now  = cur_ff;
   assign rsp_bus.speed_goal = tgt_ff;
   assign rsp_bus.in_motion  = act_ff || (cur_ff != '0);
   assign rsp_bus.ramp_phase = phase;

endmodule

// ----- sv/hbridge_pwm_speed_ramp.sv -----
// A result beat passes the s1, mid, item and output registers after its request
// is accepted. Throughput: one request per cycle while rsp_bus.ready holds; ramp and
// duty mapping are combinational, with rate*dt and /1000 done in two stages ahead.
// Reset (synchronous): speeds, move state and duties clear, bridge enabled and
// awake, config registers return to full speed limit, rate 65536, no inversion.
module hbridge_pwm_speed_ramp #(
   parameter int PWM_BITS = hps_pkg::PWM_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   hps_req_if.sink   req_bus,
   hps_rsp_if.source rsp_bus,
   hps_csr_if.sink   csr_bus
);
   import hps_pkg::*;

   hps_cfg_type  cfg_ff, cfg_in;
   logic         item_valid, item_ready;
   hps_item_type item;

   assign csr_bus.ready = !reset;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.addr)
            CSR_MAX_SPEED:  cfg_in.max_speed  = csr_bus.data[FRAC_W-1:0];
            CSR_ACCEL:      cfg_in.accel_rate = csr_bus.data[ACCEL_W-1:0];
            CSR_SLEEP_INV:  cfg_in.sleep_inv  = csr_bus.data[0];
            CSR_ENABLE_INV: cfg_in.enable_inv = csr_bus.data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_speed  <= FULL_Q16;
         cfg_ff.accel_rate <= ACCEL_W'(65536);
         cfg_ff.sleep_inv  <= 1'b0;
         cfg_ff.enable_inv <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_bus    (req_bus),
      .item_valid (item_valid),
      .item       (item),
      .item_ready (item_ready)
   );

   hps_core #(
      .PWM_BITS (PWM_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_ready (item_ready),
      .rsp_bus    (rsp_bus)
   );

endmodule
